[design/pca_pkg.sv]
// pca_pkg: command and status codes and fixed sizes for the packed counter array.
// No dependencies.
package pca_pkg;

  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned FW_RESET  = 8;

  typedef enum logic [2:0] {
    CMD_GET   = 3'd0,
    CMD_SET   = 3'd1,
    CMD_ADD   = 3'd2,
    CMD_CLEAR = 3'd3,
    CMD_PUSH  = 3'd4,
    CMD_POP   = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_ID   = 2'd1,
    ST_BIG_VAL  = 2'd2,
    ST_NO_ENTRY = 2'd3
  } status_t;

endpackage

[design/pca_ram.sv]
// pca_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module pca_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/packed_counter_array.sv]
// packed_counter_array: top level, command sequencer around the packed word store.
// Depends on pca_pkg and pca_ram.
//
// Counters of field_width bits (1..31, 0 acts as 1) are packed back to back
// into WORD_COUNT 32-bit words held in one RAM, so an entry may straddle two
// words. Every command that passes its checks reads the two words (one RAM
// port, one read a cycle), extracts the field, and writes back one or two
// words for set, add, clear and a push or pop that finds its entry. Push and
// pop examine the entries from the first until push finds an empty one or pop
// one holding the value, or none is left; range errors and unknown commands go
// straight to the done state. The sequencer returns to idle before the next
// item is taken, and a result held back by the sink stalls it in done. The
// store reads as zero after reset with no clearing pass: one valid flop per
// word masks words never written. Results sit in an output register, so the
// next item is taken while a result waits.
module packed_counter_array #(
  parameter int unsigned WORD_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // cmd[2:0], entry_id[12:3], value[43:13], zeros
  input  logic        in_tuser,   // wrap
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // read_value[30:0], status[32:31], zeros
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata
);
  localparam int unsigned TOTAL = pca_pkg::WORD_BITS * WORD_COUNT;
  localparam int unsigned SW    = $clog2(TOTAL + 64);
  localparam int unsigned AW    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_RDLO, S_RDHI, S_EVAL, S_DEC, S_WRLO, S_WRHI, S_DONE
  } state_t;

  state_t             state_r;
  logic [4:0]         fw_r;
  pca_pkg::cmd_t      cmd_r;
  logic [30:0]        val_r;
  logic               wrap_r;
  logic [SW-1:0]      start_r;
  logic [31:0]        lo_r, hi_r, hin_r;
  logic [30:0]        field_r, newv_r, rd_r;
  pca_pkg::status_t   st_r;
  logic               out_tvalid_r;
  logic [30:0]        out_rd_r;
  pca_pkg::status_t   out_st_r;
  logic [WORD_COUNT-1:0] vld_r;
  logic               rd_vld_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= 5'(pca_pkg::FW_RESET);
    end else if (cfg_we) begin
      fw_r <= cfg_wdata;
    end
  end

  logic [4:0]  fw_eff;
  logic [30:0] maxv;
  assign fw_eff = (fw_r == 5'd0) ? 5'd1 : fw_r;
  assign maxv   = 31'((32'd1 << fw_eff) - 32'd1);

  // input fields
  logic [2:0]  in_cmd;
  logic [9:0]  in_id;
  logic [30:0] in_val;
  logic [14:0] prod;
  logic        id_bad, val_big;
  assign in_cmd  = in_tdata[2:0];
  assign in_id   = in_tdata[12:3];
  assign in_val  = in_tdata[43:13];
  assign prod    = 15'(in_id) * 15'(fw_eff);
  assign id_bad  = (in_id == 10'd0) || (prod > 15'(TOTAL));
  assign val_big = in_val > maxv;

  // addressing of the current entry
  logic [SW-6:0]  w_idx;
  logic [4:0]     pos;
  logic           hi_ok;
  logic [AW-1:0]  lo_addr, hi_addr;
  assign w_idx   = start_r[SW-1:5];
  assign pos     = start_r[4:0];
  assign hi_ok   = ({1'b0, w_idx} + 1'b1) < (SW-4)'(WORD_COUNT);
  assign lo_addr = AW'(w_idx);
  assign hi_addr = AW'({1'b0, w_idx} + 1'b1);

  // RAM
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_wdata, ram_rdata, word_rd;

  pca_ram #(.WIDTH(pca_pkg::WORD_BITS), .DEPTH(WORD_COUNT)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ram_raddr = (state_r == S_RDLO) ? lo_addr : hi_addr;
  assign word_rd   = rd_vld_r ? ram_rdata : 32'd0;

  // field extract and merge
  logic [63:0] pair_rd, pair_new, mask;
  logic [31:0] hi_word;
  assign hi_word  = hi_ok ? word_rd : 32'd0;
  assign pair_rd  = {hi_word, lo_r} >> pos;
  assign mask     = 64'(maxv) << pos;
  assign pair_new = ({hi_r, lo_r} & ~mask) | ((64'(newv_r) << pos) & mask);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = lo_addr;
    ram_wdata = pair_new[31:0];
    if (state_r == S_WRLO) begin
      ram_we = 1'b1;
    end else if (state_r == S_WRHI) begin
      ram_we    = 1'b1;
      ram_waddr = hi_addr;
      ram_wdata = hin_r;
    end
  end

  // add with saturate, or on overflow subtract the maximum when wrap is set
  logic [31:0] sum, add_res;
  assign sum     = 32'(field_r) + 32'(val_r);
  assign add_res = (sum > 32'(maxv)) ? (wrap_r ? sum - 32'(maxv) : 32'(maxv)) : sum;

  // scan advance
  logic [SW-1:0] nstart;
  logic          scan_end;
  assign nstart   = start_r + SW'(fw_eff);
  assign scan_end = ({1'b0, nstart} + (SW+1)'(fw_eff)) > (SW+1)'(TOTAL);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'd0, out_st_r, out_rd_r};

  always_ff @(posedge clk) begin
    rd_vld_r <= vld_r[ram_raddr];
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      vld_r        <= '0;
    end else begin
      // result register: load from done, drop once taken
      if (state_r == S_DONE && (!out_tvalid_r || out_tready)) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (ram_we) begin
        vld_r[ram_waddr] <= 1'b1;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            cmd_r   <= pca_pkg::cmd_t'(in_cmd);
            val_r   <= in_val;
            wrap_r  <= in_tuser;
            rd_r    <= 31'd0;
            st_r    <= pca_pkg::ST_OK;
            start_r <= SW'(prod - 15'(fw_eff));
            state_r <= S_RDLO;
            case (in_cmd)
              pca_pkg::CMD_GET, pca_pkg::CMD_CLEAR: begin
                if (id_bad) begin
                  st_r    <= pca_pkg::ST_BAD_ID;
                  state_r <= S_DONE;
                end
              end
              pca_pkg::CMD_SET, pca_pkg::CMD_ADD: begin
                if (id_bad) begin
                  st_r    <= pca_pkg::ST_BAD_ID;
                  state_r <= S_DONE;
                end else if (val_big) begin
                  st_r    <= pca_pkg::ST_BIG_VAL;
                  state_r <= S_DONE;
                end
              end
              pca_pkg::CMD_PUSH: begin
                start_r <= '0;
                if (val_big) begin
                  st_r    <= pca_pkg::ST_BIG_VAL;
                  state_r <= S_DONE;
                end
              end
              pca_pkg::CMD_POP: begin
                start_r <= '0;
                // a value above the maximum never matches
                if (val_big) begin
                  st_r    <= pca_pkg::ST_NO_ENTRY;
                  state_r <= S_DONE;
                end
              end
              default: begin
                state_r <= S_DONE;
              end
            endcase
          end
        end
        S_RDLO: state_r <= S_RDHI;
        S_RDHI: begin
          lo_r    <= word_rd;
          state_r <= S_EVAL;
        end
        S_EVAL: begin
          hi_r    <= hi_word;
          field_r <= pair_rd[30:0] & maxv;
          state_r <= S_DEC;
        end
        S_DEC: begin
          state_r <= S_WRLO;
          case (cmd_r)
            pca_pkg::CMD_GET: begin
              rd_r    <= field_r;
              state_r <= S_DONE;
            end
            pca_pkg::CMD_SET:   newv_r <= val_r;
            pca_pkg::CMD_CLEAR: newv_r <= 31'd0;
            pca_pkg::CMD_ADD: begin
              newv_r <= add_res[30:0];
              rd_r   <= add_res[30:0];
            end
            pca_pkg::CMD_PUSH, pca_pkg::CMD_POP: begin
              newv_r <= (cmd_r == pca_pkg::CMD_PUSH) ? val_r : 31'd0;
              if (field_r != ((cmd_r == pca_pkg::CMD_PUSH) ? 31'd0 : val_r)) begin
                if (scan_end) begin
                  st_r    <= pca_pkg::ST_NO_ENTRY;
                  state_r <= S_DONE;
                end else begin
                  start_r <= nstart;
                  state_r <= S_RDLO;
                end
              end
            end
            default: state_r <= S_DONE;
          endcase
        end
        S_WRLO: begin
          hin_r   <= pair_new[63:32];
          state_r <= hi_ok ? S_WRHI : S_DONE;
        end
        S_WRHI: state_r <= S_DONE;
        S_DONE: begin
          if (!out_tvalid_r || out_tready) begin
            out_rd_r     <= rd_r;
            out_st_r     <= st_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // an item is taken only from idle, so the sequencer leaves idle right after
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item accepted while busy");

  // every entry visited lies inside the store
  a_entry_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RDLO |-> ({1'b0, start_r} + (SW+1)'(fw_eff)) <= (SW+1)'(TOTAL))
    else $error("entry outside store");

  // only an ok result carries a nonzero value
  a_err_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[32:31] != 2'd0 |-> out_tdata[30:0] == 31'd0)
    else $error("error result with value");

  // the upper word is written only when it exists
  a_hi_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WRHI |-> hi_ok)
    else $error("write past last word");

endmodule
